[rtl/core/simd_multiply_accumulate_unit_defines.svh]
// ----------------------------------------------------------------------------
// SIMD multiply-accumulate unit: assertion macros
// Shorthand for the concurrent checks at the end of the top level. The
// including module provides clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef SIMD_MULTIPLY_ACCUMULATE_UNIT_DEFINES_SVH
`define SIMD_MULTIPLY_ACCUMULATE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMAC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMAC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/smac_pkg.sv]
// ----------------------------------------------------------------------------
// SIMD multiply-accumulate unit package
// Function codes, status codes, beat payloads and the lane result record.
// ----------------------------------------------------------------------------
package smac_pkg;

  // Number of 32-bit word lanes in a 128-bit operand.
  localparam int unsigned NumLanes = 4;

  // Sub-function codes, numbered as in the dispatch table.
  typedef enum logic [4:0] {
    F_PMADDW = 5'd0,
    F_PSLLVW = 5'd2,
    F_PSRLVW = 5'd3,
    F_PMSUBW = 5'd4,
    F_PMFHI  = 5'd8,
    F_PMFLO  = 5'd9,
    F_PINTH  = 5'd10,
    F_PMULTW = 5'd12,
    F_PDIVW  = 5'd13,
    F_PCPYLD = 5'd14,
    F_PMADDH = 5'd16,
    F_PHMADH = 5'd17,
    F_PAND   = 5'd18,
    F_PXOR   = 5'd19,
    F_PMSUBH = 5'd20,
    F_PHMSBH = 5'd21,
    F_PEXEH  = 5'd26,
    F_PREVH  = 5'd27,
    F_PMULTH = 5'd28,
    F_PDIVBW = 5'd29,
    F_PEXEW  = 5'd30,
    F_PROT3W = 5'd31
  } funct_e;

  // Completion status carried with every result beat.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RSVD  = 2'd1,
    ST_UNIMP = 2'd2
  } status_e;

  // Four 32-bit words, word 0 least significant.
  typedef logic [NumLanes-1:0][31:0] word4_t;

  // Products formed by one lane from its pair of source words.
  typedef struct packed {
    logic [63:0] wprod;    // signed word product
    logic [31:0] hprod_hi; // signed product of the upper halfwords
    logic [31:0] hprod_lo; // signed product of the lower halfwords
  } lane_res_t;

  // Input beat.
  typedef struct packed {
    logic [4:0]  funct;
    logic [63:0] rs_lo;
    logic [63:0] rs_hi;
    logic [63:0] rt_lo;
    logic [63:0] rt_hi;
  } in_t;

  // Output beat.
  typedef struct packed {
    logic [63:0] rd_lo;
    logic [63:0] rd_hi;
    logic        write_rd;
    logic [1:0]  status;
  } out_t;

endpackage

[rtl/core/smac_lane.sv]
// ----------------------------------------------------------------------------
// SIMD multiply-accumulate lane
// Signed word product and the two signed halfword products of one word pair.
// ----------------------------------------------------------------------------
module smac_lane (
  input  logic [31:0]          a_i,
  input  logic [31:0]          b_i,
  output smac_pkg::lane_res_t  res_o
);
  import smac_pkg::*;

  logic signed [63:0] wprod;
  logic signed [31:0] hprod_lo;
  logic signed [31:0] hprod_hi;

  // Operands are sign-extended to the product width by the assignment context.
  assign wprod    = $signed(a_i) * $signed(b_i);
  assign hprod_lo = $signed(a_i[15:0]) * $signed(b_i[15:0]);
  assign hprod_hi = $signed(a_i[31:16]) * $signed(b_i[31:16]);

  assign res_o.wprod    = wprod;
  assign res_o.hprod_lo = hprod_lo;
  assign res_o.hprod_hi = hprod_hi;

endmodule

[rtl/core/smac_acc.sv]
// ----------------------------------------------------------------------------
// SIMD multiply-accumulate merge stage
// Combines the lane products with HI and LO, and selects the result beat.
// ----------------------------------------------------------------------------
module smac_acc (
  input  logic [4:0]                                   funct_i,
  input  smac_pkg::lane_res_t [smac_pkg::NumLanes-1:0] lanes_i,
  input  smac_pkg::word4_t                             move_i,
  input  smac_pkg::word4_t                             hi_i,
  input  smac_pkg::word4_t                             lo_i,
  output smac_pkg::word4_t                             hi_d_o,
  output smac_pkg::word4_t                             lo_d_o,
  output smac_pkg::out_t                               res_o
);
  import smac_pkg::*;

  // Accumulate and result selection.
  always_comb begin
    logic [63:0] acc;
    logic [63:0] sum;
    word4_t      plo;
    word4_t      phi;
    word4_t      rdw;
    status_e     st;

    hi_d_o = hi_i;
    lo_d_o = lo_i;
    rdw    = '0;
    st     = ST_OK;
    acc    = '0;
    sum    = '0;

    // Halfword products routed to their LO and HI words.
    plo = {lanes_i[2].hprod_hi, lanes_i[2].hprod_lo,
           lanes_i[0].hprod_hi, lanes_i[0].hprod_lo};
    phi = {lanes_i[3].hprod_hi, lanes_i[3].hprod_lo,
           lanes_i[1].hprod_hi, lanes_i[1].hprod_lo};

    case (funct_i)
      F_PMADDW, F_PMSUBW, F_PMULTW: begin
        for (int j = 0; j < NumLanes; j += 2) begin
          acc = {hi_i[j], lo_i[j]};
          if (funct_i == F_PMADDW) begin
            sum = acc + lanes_i[j].wprod;
          end else if (funct_i == F_PMSUBW) begin
            sum = acc - lanes_i[j].wprod;
          end else begin
            sum = lanes_i[j].wprod;
          end
          lo_d_o[j]   = sum[31:0];
          lo_d_o[j+1] = {32{sum[31]}};
          hi_d_o[j]   = sum[63:32];
          hi_d_o[j+1] = {32{sum[63]}};
          rdw[j]      = sum[31:0];
          rdw[j+1]    = sum[63:32];
        end
      end
      F_PMADDH, F_PMSUBH, F_PMULTH: begin
        for (int k = 0; k < NumLanes; k++) begin
          if (funct_i == F_PMADDH) begin
            lo_d_o[k] = lo_i[k] + plo[k];
            hi_d_o[k] = hi_i[k] + phi[k];
          end else if (funct_i == F_PMSUBH) begin
            lo_d_o[k] = lo_i[k] - plo[k];
            hi_d_o[k] = hi_i[k] - phi[k];
          end else begin
            lo_d_o[k] = plo[k];
            hi_d_o[k] = phi[k];
          end
        end
        rdw = {hi_d_o[2], lo_d_o[2], hi_d_o[0], lo_d_o[0]};
      end
      F_PMFHI: begin
        rdw = hi_i;
      end
      F_PMFLO: begin
        rdw = lo_i;
      end
      F_PINTH, F_PCPYLD, F_PAND, F_PXOR, F_PEXEH, F_PREVH, F_PEXEW, F_PROT3W: begin
        rdw = move_i;
      end
      F_PSLLVW, F_PSRLVW, F_PDIVW, F_PHMADH, F_PHMSBH, F_PDIVBW: begin
        st = ST_UNIMP;
      end
      default: begin
        st = ST_RSVD;
      end
    endcase

    res_o.rd_lo    = {rdw[1], rdw[0]};
    res_o.rd_hi    = {rdw[3], rdw[2]};
    res_o.write_rd = (st == ST_OK);
    res_o.status   = st;
  end

endmodule

[rtl/core/simd_multiply_accumulate_unit.sv]
// ----------------------------------------------------------------------------
// SIMD multiply-accumulate unit
// 128-bit multimedia execute unit with signed word and halfword multiply,
// multiply-add and multiply-subtract into HI and LO, plus data movement.
// ----------------------------------------------------------------------------
// Usage:
// An input beat carries a function code and the two 128-bit sources rs and
// rt; each accepted beat yields exactly one output beat with the 128-bit
// destination, a write flag and a status. Both channels use valid/ready.
// A beat accepted at the input is registered in the first stage and then
// in the output register, which holds it until taken. Throughput is one
// beat per cycle while the receiver does not stall. The first stage forms
// all products in four word lanes; the second stage adds them into HI and
// LO, a 64-bit accumulate in lanes 0 and 2 for word codes, and closes that
// loop itself, so dependent multiply-adds may follow back to back.
// Reset clears HI, LO and both stage valids. When the receiver stalls, the
// output register holds its beat, the first stage still takes a beat if empty,
// and then the input ready drops until the output drains.
// ----------------------------------------------------------------------------
`include "simd_multiply_accumulate_unit_defines.svh"

module simd_multiply_accumulate_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  smac_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output smac_pkg::out_t out_data_o
);
  import smac_pkg::*;

  word4_t                    a_w;
  word4_t                    b_w;
  logic [7:0][15:0]          a_h;
  logic [7:0][15:0]          b_h;
  word4_t                    move_d;
  lane_res_t [NumLanes-1:0]  lanes_d;

  logic                      s1_valid_q;
  logic [4:0]                s1_funct_q;
  lane_res_t [NumLanes-1:0]  s1_lanes_q;
  word4_t                    s1_move_q;

  word4_t                    hi_q;
  word4_t                    lo_q;
  word4_t                    hi_d;
  word4_t                    lo_d;
  out_t                      acc_res;

  logic                      out_valid_q;
  out_t                      out_data_q;
  logic                      advance;
  logic                      commit;

  assign a_w = {in_data_i.rs_hi, in_data_i.rs_lo};
  assign b_w = {in_data_i.rt_hi, in_data_i.rt_lo};
  assign a_h = a_w;
  assign b_h = b_w;

  // Handshake: the output register frees when empty or taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign commit     = advance && s1_valid_q;
  assign in_ready_o = advance || !s1_valid_q;

  // Word lanes forming the products.
  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    smac_lane u_lane (
      .a_i   (a_w[i]),
      .b_i   (b_w[i]),
      .res_o (lanes_d[i])
    );
  end

  // Data movement and bitwise operations on the sources.
  always_comb begin
    move_d = '0;
    case (in_data_i.funct)
      F_PINTH: begin
        for (int i = 0; i < NumLanes; i++) begin
          move_d[i] = {a_h[i+4], b_h[i]};
        end
      end
      F_PCPYLD: begin
        move_d = {a_w[1], a_w[0], b_w[1], b_w[0]};
      end
      F_PAND: begin
        move_d = a_w & b_w;
      end
      F_PXOR: begin
        move_d = a_w ^ b_w;
      end
      F_PEXEH: begin
        move_d = {b_h[7], b_h[4], b_h[5], b_h[6], b_h[3], b_h[0], b_h[1], b_h[2]};
      end
      F_PREVH: begin
        move_d = {b_h[4], b_h[5], b_h[6], b_h[7], b_h[0], b_h[1], b_h[2], b_h[3]};
      end
      F_PEXEW: begin
        move_d = {b_w[3], b_w[0], b_w[1], b_w[2]};
      end
      F_PROT3W: begin
        move_d = {b_w[3], b_w[0], b_w[2], b_w[1]};
      end
      default: begin
        move_d = '0;
      end
    endcase
  end

  // Stage one valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_funct_q <= in_data_i.funct;
      s1_lanes_q <= lanes_d;
      s1_move_q  <= move_d;
    end
  end

  // Merge stage: accumulate into HI and LO and pick the result.
  smac_acc u_acc (
    .funct_i (s1_funct_q),
    .lanes_i (s1_lanes_q),
    .move_i  (s1_move_q),
    .hi_i    (hi_q),
    .lo_i    (lo_q),
    .hi_d_o  (hi_d),
    .lo_d_o  (lo_d),
    .res_o   (acc_res)
  );

  // HI and LO update when a beat leaves stage one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (commit) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= acc_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A beat leaving stage one is on the output in the next cycle.
  `SMAC_ASSERT_NEXT(a_commit_shows, commit, out_valid_q, "committed beat not on output")
  // Reserved and unimplemented codes leave HI and LO untouched.
  `SMAC_ASSERT_NEXT(a_noop_keeps_hilo, commit && (acc_res.status != ST_OK),
                    $stable(hi_q) && $stable(lo_q), "HI/LO changed by a no-op code")
  // The output only fills from a valid first stage.
  `SMAC_ASSERT_SAME(a_out_from_s1, $rose(out_valid_q), $past(s1_valid_q),
                    "output valid without a stage one beat")

endmodule

[tb/sv/simd_multiply_accumulate_unit_test.sv]
// ----------------------------------------------------------------------------
// SIMD multiply-accumulate unit testbench
// Drives instruction beats through the valid/ready input channel and compares
// every output beat against a cycle-free model of the unit, which is kept in
// step with the HI and LO registers. Directed beats cover each operation and
// the arithmetic extremes; random runs of multiply-accumulate chains, ended by
// reads of HI or LO and mixed with random codes, follow under varying stalls.
// ----------------------------------------------------------------------------
module simd_multiply_accumulate_unit_test;
  import smac_pkg::*;

  // A code that the dispatch table leaves reserved.
  localparam logic [4:0] RsvdFunct = 5'd25;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // Model copy of the HI and LO registers.
  word4_t hi_reg = '0;
  word4_t lo_reg = '0;

  out_t pending_rd_q[$];
  out_t rd_expected;
  int   error_count   = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  simd_multiply_accumulate_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Executes one sub-instruction on the model and returns the result beat.
  function automatic out_t execute_mmi(in_t beat);
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] d;
    logic [31:0]  aw;
    logic [31:0]  bw;
    logic [15:0]  ah;
    logic [15:0]  bh;
    logic [63:0]  acc;
    logic [63:0]  prod;
    logic [63:0]  r;
    logic [31:0]  prods [8];
    int           src;
    out_t         res;
    a = {beat.rs_hi, beat.rs_lo};
    b = {beat.rt_hi, beat.rt_lo};
    d = '0;
    res.status = ST_OK;
    case (beat.funct)
      F_PMADDW, F_PMSUBW, F_PMULTW: begin
        // Lanes 0 and 2 each form a 64-bit value split across HI and LO.
        for (int i = 0; i < 4; i += 2) begin
          aw   = a[32*i +: 32];
          bw   = b[32*i +: 32];
          acc  = {hi_reg[i], lo_reg[i]};
          prod = {{32{aw[31]}}, aw} * {{32{bw[31]}}, bw};
          case (beat.funct)
            F_PMADDW: r = acc + prod;
            F_PMSUBW: r = acc - prod;
            default:  r = prod;
          endcase
          lo_reg[i]         = r[31:0];
          lo_reg[i+1]       = {32{r[31]}};
          hi_reg[i]         = r[63:32];
          hi_reg[i+1]       = {32{r[63]}};
          d[32*i +: 64]     = r;
        end
      end
      F_PMADDH, F_PMSUBH, F_PMULTH: begin
        for (int k = 0; k < 8; k++) begin
          ah       = a[16*k +: 16];
          bh       = b[16*k +: 16];
          prods[k] = {{16{ah[15]}}, ah} * {{16{bh[15]}}, bh};
        end
        // LO takes products 0, 1, 4, 5 and HI takes 2, 3, 6, 7.
        for (int k = 0; k < 4; k++) begin
          src = (k % 2) + 4 * (k / 2);
          case (beat.funct)
            F_PMADDH: begin
              lo_reg[k] = lo_reg[k] + prods[src];
              hi_reg[k] = hi_reg[k] + prods[src+2];
            end
            F_PMSUBH: begin
              lo_reg[k] = lo_reg[k] - prods[src];
              hi_reg[k] = hi_reg[k] - prods[src+2];
            end
            default: begin
              lo_reg[k] = prods[src];
              hi_reg[k] = prods[src+2];
            end
          endcase
        end
        d = {hi_reg[2], lo_reg[2], hi_reg[0], lo_reg[0]};
      end
      F_PMFHI: d = hi_reg;
      F_PMFLO: d = lo_reg;
      F_PINTH: begin
        for (int i = 0; i < 4; i++) begin
          d[32*i +: 32] = {a[16*(i+4) +: 16], b[16*i +: 16]};
        end
      end
      F_PCPYLD: d = {a[63:0], b[63:0]};
      F_PAND:   d = a & b;
      F_PXOR:   d = a ^ b;
      F_PEXEH: begin
        for (int j = 0; j < 8; j += 4) begin
          d[16*j +: 32]      = {b[16*(j+1) +: 16], b[16*(j+2) +: 16]};
          d[16*j+32 +: 32]   = {b[16*(j+3) +: 16], b[16*j +: 16]};
        end
      end
      F_PREVH: begin
        for (int j = 0; j < 8; j += 4) begin
          d[16*j +: 32]      = {b[16*(j+2) +: 16], b[16*(j+3) +: 16]};
          d[16*j+32 +: 32]   = {b[16*j +: 16], b[16*(j+1) +: 16]};
        end
      end
      F_PEXEW:  d = {b[127:96], b[31:0], b[63:32], b[95:64]};
      F_PROT3W: d = {b[127:96], b[31:0], b[95:64], b[63:32]};
      F_PSLLVW, F_PSRLVW, F_PDIVW, F_PHMADH, F_PHMSBH, F_PDIVBW: begin
        res.status = ST_UNIMP;
      end
      default: res.status = ST_RSVD;
    endcase
    res.rd_lo    = d[63:0];
    res.rd_hi    = d[127:64];
    res.write_rd = (res.status == ST_OK);
    return res;
  endfunction

  function automatic in_t beat_of(logic [4:0] f, logic [127:0] rs, logic [127:0] rt);
    in_t beat;
    beat.funct = f;
    beat.rs_lo = rs[63:0];
    beat.rs_hi = rs[127:64];
    beat.rt_lo = rt[63:0];
    beat.rt_hi = rt[127:64];
    return beat;
  endfunction

  // Random doubleword, with halfwords often forced to arithmetic corners.
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(2) == 0) begin
      for (int h = 0; h < 4; h++) begin
        case ($urandom_range(5))
          0:       v[16*h +: 16] = 16'h0000;
          1:       v[16*h +: 16] = 16'hffff;
          2:       v[16*h +: 16] = 16'h8000;
          3:       v[16*h +: 16] = 16'h7fff;
          default: ;
        endcase
      end
    end
    return v;
  endfunction

  function automatic in_t rand_beat(logic [4:0] f);
    return beat_of(f, {rand_operand(), rand_operand()}, {rand_operand(), rand_operand()});
  endfunction

  // Sends one beat; entered and left at a falling edge. The model runs at the
  // accepting edge so that it sees beats in the order the unit does.
  task automatic send_beat(input in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rd_q.push_back(execute_mmi(beat));
    @(negedge clk_i);
  endtask

  // Holds the input channel idle until every pending result has come back.
  task automatic idle_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_rd_q.size() != 0);
  endtask

  // Bitwise logic, copies, interleave and the halfword and word shuffles.
  task automatic test_data_movement();
    logic [127:0] pat_rs;
    logic [127:0] pat_rt;
    pat_rs = 128'h1111_2222_3333_4444_5555_6666_7777_8888;
    pat_rt = 128'hc008_b007_a006_9005_8004_7003_f002_0001;
    send_beat(beat_of(F_PAND, '1, 128'ha5a5_5a5a_0f0f_f0f0_ffff_0000_1234_8765));
    send_beat(beat_of(F_PXOR, '1, '0));
    send_beat(beat_of(F_PCPYLD, pat_rs, pat_rt));
    send_beat(beat_of(F_PINTH, pat_rs, pat_rt));
    send_beat(beat_of(F_PEXEH, pat_rs, pat_rt));
    send_beat(beat_of(F_PREVH, pat_rs, pat_rt));
    send_beat(beat_of(F_PEXEW, pat_rs, pat_rt));
    send_beat(beat_of(F_PROT3W, pat_rs, pat_rt));
  endtask

  // Word multiplies at the signed extremes, then reads of HI and LO.
  task automatic test_word_multiply();
    send_beat(beat_of(F_PMULTW, 128'h0000_0000_8000_0000_0000_0000_8000_0000,
                      128'h0000_0000_8000_0000_ffff_ffff_8000_0000));
    send_beat(beat_of(F_PMADDW, 128'h0000_0000_7fff_ffff_0000_0000_7fff_ffff,
                      128'h0000_0000_7fff_ffff_0000_0000_8000_0000));
    send_beat(beat_of(F_PMSUBW, 128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff,
                      128'h0000_0000_0000_0001_0000_0000_8000_0000));
    send_beat(beat_of(F_PMFHI, '0, '0));
    send_beat(beat_of(F_PMFLO, '1, '1));
  endtask

  // Halfword multiplies whose sums wrap past 32 bits.
  task automatic test_halfword_multiply();
    send_beat(beat_of(F_PMULTH, {8{16'h8000}}, {8{16'h8000}}));
    send_beat(beat_of(F_PMADDH, {8{16'h8000}}, {8{16'h8000}}));
    send_beat(beat_of(F_PMADDH, {8{16'h8000}}, {8{16'h8000}}));
    send_beat(beat_of(F_PMSUBH, {8{16'h7fff}}, {8{16'hffff}}));
    send_beat(beat_of(F_PMFLO, '0, '0));
    send_beat(beat_of(F_PMFHI, '0, '0));
  endtask

  // Reserved and unimplemented codes report status and leave HI and LO alone.
  task automatic test_unused_codes();
    send_beat(beat_of(RsvdFunct, '1, '1));
    send_beat(beat_of(F_PDIVW, '1, '1));
    send_beat(beat_of(F_PMFHI, '0, '0));
  endtask

  // Mostly accumulate chains with random operands, the rest random codes.
  task automatic test_random(input int n_beats, input int send_pct, input int recv_pct);
    logic [4:0] word_ops [3];
    logic [4:0] half_ops [3];
    int         sent;
    int         run_len;
    int         idx;
    logic       wide;
    word_ops      = '{F_PMULTW, F_PMADDW, F_PMSUBW};
    half_ops      = '{F_PMULTH, F_PMADDH, F_PMSUBH};
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent          = 0;
    while (sent < n_beats) begin
      if ($urandom_range(9) < 3) begin
        send_beat(rand_beat(5'($urandom_range(31))));
        sent++;
      end else begin
        wide    = 1'($urandom_range(1));
        run_len = $urandom_range(6, 1);
        for (int j = 0; j < run_len; j++) begin
          // A chain often opens with a plain multiply to restart HI and LO.
          idx = (j == 0 && $urandom_range(1) == 1) ? 0 : $urandom_range(2, 1);
          send_beat(rand_beat(wide ? word_ops[idx] : half_ops[idx]));
        end
        send_beat(rand_beat($urandom_range(1) ? F_PMFHI : F_PMFLO));
        sent += run_len + 1;
      end
    end
  endtask

  // Receiver stalls at random.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Each accepted result beat is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rd_q.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing actual %h",
                 $time, out_data_o);
        error_count++;
      end else begin
        rd_expected = pending_rd_q.pop_front();
        check_field("rd_lo", rd_expected.rd_lo, out_data_o.rd_lo);
        check_field("rd_hi", rd_expected.rd_hi, out_data_o.rd_hi);
        check_field("write_rd", 64'(rd_expected.write_rd), 64'(out_data_o.write_rd));
        check_field("status", 64'(rd_expected.status), 64'(out_data_o.status));
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 30;
    recv_idle_pct = 76;
    test_data_movement();
    test_word_multiply();
    test_halfword_multiply();
    test_unused_codes();
    idle_until_drained();
    test_random(650, 30, 76);
    test_random(650, 76, 30);
    idle_until_drained();
    test_random(650, 0, 0);
    in_valid_i <= 1'b0;
    while (pending_rd_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (error_count == 0 && pending_rd_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
